@@ src/cmg_pkg.sv @@
// Shared types, widths and constants for the cylinder mesh generator.
// Depends on nothing; every other file imports it.
package cmg_pkg;

   localparam int MAX_POINTS = 256;
   localparam int MAX_RINGS = 256;
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_IDX_W = $clog2(SINE_ENTRIES);
   localparam int SINE_AW = SINE_IDX_W + 1;
   localparam int SINE_W = 15;
   localparam int PHASE_W = 16;
   localparam int QUARTER_W = PHASE_W - 2;

   localparam int CNT_W = 9;
   localparam int STEP_W = 16;
   localparam int POINT_W = 8;
   localparam int RING_W = 8;
   localparam int SLOT_W = 17;
   localparam int VERT_W = 16;
   localparam int POS_W = 17;
   localparam int Z_W = 24;
   localparam int TEX_W = 16;

   localparam int REQ_PACK_W = POINT_W + RING_W + 1;
   localparam int REQ_W = ((REQ_PACK_W + 7) / 8) * 8;
   localparam int RSP_PACK_W = SLOT_W + 3 * VERT_W + 2 * POS_W + Z_W + 2 * TEX_W;
   localparam int RSP_W = ((RSP_PACK_W + 7) / 8) * 8;
   localparam int VERT_LO = SLOT_W;
   localparam int ATTR_LO = SLOT_W + 3 * VERT_W;
   localparam int ATTR_W = 2 * POS_W + Z_W + 2 * TEX_W;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_NUM_RINGS   = 3'd0,
      REG_NUM_POINTS  = 3'd1,
      REG_RADIUS      = 3'd2,
      REG_HEIGHT_STEP = 3'd3,
      REG_PHASE_STEP  = 3'd4,
      REG_U_STEP      = 3'd5,
      REG_V_STEP      = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]  num_rings;
      logic [CNT_W-1:0]  num_points;
      logic [STEP_W-1:0] radius;
      logic [STEP_W-1:0] height_step;
      logic [STEP_W-1:0] phase_step;
      logic [STEP_W-1:0] u_step;
      logic [STEP_W-1:0] v_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      num_rings:   CNT_W'(3),
      num_points:  CNT_W'(3),
      radius:      STEP_W'(256),
      height_step: STEP_W'(256),
      phase_step:  STEP_W'(21845),
      u_step:      STEP_W'(21845),
      v_step:      STEP_W'(21845)
   };

endpackage

@@ src/cmg_sine_rom.sv @@
// Quarter-wave sine table with two registered read ports (sine and cosine).
// The table contents are built at elaboration; uses cmg_pkg.
module cmg_sine_rom
   import cmg_pkg::*;
(
   input  logic               clock,
   input  logic               enable,
   input  logic [SINE_AW-1:0] sin_addr,
   input  logic [SINE_AW-1:0] cos_addr,
   output logic [SINE_W-1:0]  sin_data_ff,
   output logic [SINE_W-1:0]  cos_data_ff
);

   typedef logic [SINE_W-1:0] sine_tab_type [0:SINE_ENTRIES];

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Taylor series through x^13 in unsigned Q30, rounded to Q0.15.
   function automatic sine_tab_type build_table();
      sine_tab_type tab;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         x = (HALF_PI_Q30 * 64'(k)) / SINE_ENTRIES;
         x2 = (x * x) >> 30;
         term = x;
         sum = signed'(x);
         term = ((term * x2) >> 30) / 6;
         sum = sum - signed'(term);
         term = ((term * x2) >> 30) / 20;
         sum = sum + signed'(term);
         term = ((term * x2) >> 30) / 42;
         sum = sum - signed'(term);
         term = ((term * x2) >> 30) / 72;
         sum = sum + signed'(term);
         term = ((term * x2) >> 30) / 110;
         sum = sum - signed'(term);
         term = ((term * x2) >> 30) / 156;
         sum = sum + signed'(term);
         if (sum < 0) begin
            sum = 0;
         end
         r = (sum * 32767 + 64'sd536870912) / 64'sd1073741824;
         if (r > 32767) begin
            r = 32767;
         end
         tab[k] = r[SINE_W-1:0];
      end
      tab[SINE_ENTRIES] = SINE_W'(32767);
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_table();

   always_ff @(posedge clock) begin
      if (enable) begin
         sin_data_ff <= SINE_TAB[sin_addr];
         cos_data_ff <= SINE_TAB[cos_addr];
      end
   end

endmodule

@@ src/cmg_scale.sv @@
// One registered stage that scales a Q0.15 sine magnitude by the Q8.8 radius.
// Rounds to nearest with ties up; uses cmg_pkg.
module cmg_scale
   import cmg_pkg::*;
(
   input  logic              clock,
   input  logic              enable,
   input  logic [SINE_W-1:0] mag,
   input  logic [STEP_W-1:0] radius,
   output logic [POS_W-1:0]  scaled_ff
);

   localparam int PROD_W = SINE_W + STEP_W + 1;

   logic [PROD_W-1:0] prod;
   logic [POS_W-1:0]  scaled_in;

   assign prod = PROD_W'(mag) * PROD_W'(radius) + PROD_W'(1 << (SINE_W - 1));
   assign scaled_in = POS_W'(prod >> SINE_W);

   always_ff @(posedge clock) begin
      if (enable) begin
         scaled_ff <= scaled_in;
      end
   end

endmodule

@@ src/cylinder_mesh_generator.sv @@
// Top level of the cylinder mesh generator: config registers and a four-stage pipeline.
// Uses cmg_pkg, cmg_sine_rom and cmg_scale.
//
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata point, ring, half; tuser command
// rsp      out        rsp_tvalid/tready    tdata slot, verts, position, texture; tuser range flag
// csr      in         csr_valid/ready      csr_index register, csr_data value
//
// One request per cycle unless a stalled result backs up to the input; each result
// follows its request through the registered index products, the registered sine table
// read, the radius multiply and the output register. Reset is synchronous and clears all
// valid bits and the config registers to their defaults. A stalled result holds each
// stage only as far back as needed, so empty stages still take requests.
module cylinder_mesh_generator
   import cmg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,  // point_number, ring_number, half, zero pad
   input  logic                  req_tuser,  // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // slot_index, vert_a, vert_b, vert_c, pos_x,
                                             // pos_y, pos_z, tex_u, tex_v, zero pad
   output logic                  rsp_tuser,  // out_of_range
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef struct packed {
      logic                  oor;
      logic                  cmd;
      logic                  half;
      logic                  last;
      logic [RING_W-1:0]     ring;
      logic [SLOT_W-1:0]     pn;
      logic [SLOT_W-1:0]     pl;
      logic [PHASE_W-1:0]    phase;
      logic [Z_W-1:0]        z;
      logic [Z_W-1:0]        tu;
      logic [Z_W-1:0]        tv;
   } stage_a_type;

   typedef struct packed {
      logic                  oor;
      logic                  cmd;
      logic [SLOT_W-1:0]     slot;
      logic [VERT_W-1:0]     va;
      logic [VERT_W-1:0]     vb;
      logic [VERT_W-1:0]     vc;
      logic [Z_W-1:0]        z;
      logic [TEX_W-1:0]      tu;
      logic [TEX_W-1:0]      tv;
      logic                  sin_neg;
      logic                  cos_neg;
   } stage_b_type;

   cfg_type     cfg_ff, cfg_in;
   stage_a_type a_ff, a_in;
   stage_b_type b_ff, b_in;
   stage_b_type c_ff;
   logic        a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic        ready_a, ready_b, ready_c, ready_d;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic        rsp_oor_ff;

   logic                  req_cmd, req_half;
   logic [POINT_W-1:0]    req_point;
   logic [RING_W-1:0]     req_ring;
   logic                  bad_size, bad_index;
   logic [CNT_W-1:0]      layers;

   logic [SLOT_W-1:0]     a_full, b_full, c_full, face_slot;
   logic [PHASE_W-1:0]    cos_phase;
   logic [SINE_IDX_W-1:0] sin_idx, cos_idx;
   logic [SINE_AW-1:0]    sin_addr, cos_addr;
   logic [SINE_W-1:0]     sin_mag, cos_mag;
   logic [POS_W-1:0]      x_mag, y_mag, pos_x, pos_y;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      case (reg_index_type'(csr_index))
         REG_NUM_RINGS:   cfg_in.num_rings = csr_data[CNT_W-1:0];
         REG_NUM_POINTS:  cfg_in.num_points = csr_data[CNT_W-1:0];
         REG_RADIUS:      cfg_in.radius = csr_data;
         REG_HEIGHT_STEP: cfg_in.height_step = csr_data;
         REG_PHASE_STEP:  cfg_in.phase_step = csr_data;
         REG_U_STEP:      cfg_in.u_step = csr_data;
         REG_V_STEP:      cfg_in.v_step = csr_data;
         default:         cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_ff <= cfg_in;
      end
   end

   assign ready_d = !d_valid_ff || rsp_tready;
   assign ready_c = !c_valid_ff || ready_d;
   assign ready_b = !b_valid_ff || ready_c;
   assign ready_a = !a_valid_ff || ready_b;
   assign req_tready = ready_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            a_valid_ff <= req_tvalid;
         end
         if (ready_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (ready_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (ready_d) begin
            d_valid_ff <= c_valid_ff;
         end
      end
   end

   // Stage A: range checks and the small index products.
   assign req_cmd = req_tuser;
   assign req_point = req_tdata[POINT_W-1:0];
   assign req_ring = req_tdata[POINT_W +: RING_W];
   assign req_half = req_tdata[POINT_W + RING_W];
   assign layers = cfg_ff.num_rings - CNT_W'(1);

   assign bad_size = (cfg_ff.num_rings < CNT_W'(3)) || (cfg_ff.num_points < CNT_W'(3))
                     || (32'(cfg_ff.num_rings) > MAX_RINGS)
                     || (32'(cfg_ff.num_points) > MAX_POINTS);
   assign bad_index = (CNT_W'(req_point) >= cfg_ff.num_points)
                      || (req_cmd ? (CNT_W'(req_ring) >= layers)
                                  : (CNT_W'(req_ring) >= cfg_ff.num_rings));

   always_comb begin
      a_in.oor = bad_size || bad_index;
      a_in.cmd = req_cmd;
      a_in.half = req_half;
      a_in.last = (CNT_W'(req_point) == cfg_ff.num_points - CNT_W'(1));
      a_in.ring = req_ring;
      a_in.pn = SLOT_W'(req_point) * SLOT_W'(cfg_ff.num_rings);
      a_in.pl = SLOT_W'(req_point) * SLOT_W'(layers);
      a_in.phase = PHASE_W'(PHASE_W'(req_point) * cfg_ff.phase_step);
      a_in.z = Z_W'(req_ring) * Z_W'(cfg_ff.height_step);
      a_in.tu = Z_W'(req_point) * Z_W'(cfg_ff.u_step);
      a_in.tv = Z_W'(req_ring) * Z_W'(cfg_ff.v_step);
   end

   always_ff @(posedge clock) begin
      if (ready_a) begin
         a_ff <= a_in;
      end
   end

   // Stage B: face indices, texture saturation and sine table addresses.
   assign a_full = a_ff.pn + SLOT_W'(a_ff.ring);
   assign face_slot = SLOT_W'(a_ff.ring) + (a_ff.half ? SLOT_W'(layers) : '0)
                      + SLOT_W'({a_ff.pl, 1'b0});

   always_comb begin
      b_full = a_full + SLOT_W'(1);
      c_full = a_full + SLOT_W'(1) + SLOT_W'(cfg_ff.num_rings);
      if (a_ff.half) begin
         c_full = a_full + SLOT_W'(cfg_ff.num_rings);
         b_full = a_full + SLOT_W'(cfg_ff.num_rings) + SLOT_W'(1);
      end
      if (a_ff.last) begin
         if (a_ff.half) begin
            b_full = SLOT_W'(a_ff.ring) + SLOT_W'(1);
            c_full = SLOT_W'(a_ff.ring);
         end else begin
            c_full = SLOT_W'(a_ff.ring) + SLOT_W'(1);
         end
      end
   end

   assign cos_phase = a_ff.phase + PHASE_W'(1 << QUARTER_W);
   assign sin_idx = SINE_IDX_W'(a_ff.phase[QUARTER_W-1:0] >> (QUARTER_W - SINE_IDX_W));
   assign cos_idx = SINE_IDX_W'(cos_phase[QUARTER_W-1:0] >> (QUARTER_W - SINE_IDX_W));
   assign sin_addr = a_ff.phase[QUARTER_W] ? SINE_AW'(SINE_ENTRIES) - SINE_AW'(sin_idx)
                                           : SINE_AW'(sin_idx);
   assign cos_addr = cos_phase[QUARTER_W] ? SINE_AW'(SINE_ENTRIES) - SINE_AW'(cos_idx)
                                          : SINE_AW'(cos_idx);

   always_comb begin
      b_in.oor = a_ff.oor;
      b_in.cmd = a_ff.cmd;
      b_in.slot = a_ff.cmd ? face_slot : a_full;
      b_in.va = a_ff.cmd ? a_full[VERT_W-1:0] : '0;
      b_in.vb = a_ff.cmd ? b_full[VERT_W-1:0] : '0;
      b_in.vc = a_ff.cmd ? c_full[VERT_W-1:0] : '0;
      b_in.z = a_ff.z;
      b_in.tu = (|a_ff.tu[Z_W-1:TEX_W]) ? '1 : a_ff.tu[TEX_W-1:0];
      b_in.tv = (|a_ff.tv[Z_W-1:TEX_W]) ? '1 : a_ff.tv[TEX_W-1:0];
      b_in.sin_neg = a_ff.phase[PHASE_W-1];
      b_in.cos_neg = cos_phase[PHASE_W-1];
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_ff <= b_in;
      end
   end

   cmg_sine_rom u_rom (
      .clock       (clock),
      .enable      (ready_b),
      .sin_addr    (sin_addr),
      .cos_addr    (cos_addr),
      .sin_data_ff (sin_mag),
      .cos_data_ff (cos_mag)
   );

   // Stage C: radius products.
   always_ff @(posedge clock) begin
      if (ready_c) begin
         c_ff <= b_ff;
      end
   end

   cmg_scale u_scale_x (
      .clock     (clock),
      .enable    (ready_c),
      .mag       (sin_mag),
      .radius    (cfg_ff.radius),
      .scaled_ff (x_mag)
   );

   cmg_scale u_scale_y (
      .clock     (clock),
      .enable    (ready_c),
      .mag       (cos_mag),
      .radius    (cfg_ff.radius),
      .scaled_ff (y_mag)
   );

   // Stage D: signs, field selection and the output register.
   assign pos_x = c_ff.sin_neg ? POS_W'(~x_mag + POS_W'(1)) : x_mag;
   assign pos_y = c_ff.cos_neg ? POS_W'(~y_mag + POS_W'(1)) : y_mag;

   always_comb begin
      rsp_data_in = '0;
      if (!c_ff.oor) begin
         if (c_ff.cmd) begin
            rsp_data_in = RSP_W'({c_ff.vc, c_ff.vb, c_ff.va, c_ff.slot});
         end else begin
            rsp_data_in = RSP_W'({c_ff.tv, c_ff.tu, c_ff.z, pos_y, pos_x,
                                  {(3 * VERT_W){1'b0}}, c_ff.slot});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready_d) begin
         rsp_data_ff <= rsp_data_in;
         rsp_oor_ff <= c_ff.oor;
      end
   end

   assign rsp_tvalid = d_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_oor_ff;

endmodule

@@ src/cmg_checker.sv @@
// Port-level checks for the cylinder mesh generator, bound to the top level.
// Uses cmg_pkg.
module cmg_checker
   import cmg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("out of range result carries data");

   a_kind_split: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[VERT_LO +: 3 * VERT_W] == '0
                     || rsp_tdata[ATTR_LO +: ATTR_W] == '0)
      else $error("result mixes face and vertex fields");

endmodule

bind cylinder_mesh_generator cmg_checker u_cmg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ sim/cmg_result_checker.sv @@
// Result checker for the cylinder mesh generator testbench.
// Watches the request, result and register channels, predicts each result and compares it.
// Depends on cmg_pkg for widths, register indexes and the reset settings.
module cmg_result_checker
   import cmg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic              out_of_range;
      logic [SLOT_W-1:0] slot_index;
      logic [VERT_W-1:0] vert_a;
      logic [VERT_W-1:0] vert_b;
      logic [VERT_W-1:0] vert_c;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [Z_W-1:0]    pos_z;
      logic [TEX_W-1:0]  tex_u;
      logic [TEX_W-1:0]  tex_v;
   } mesh_element_type;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam int PRINT_LIMIT = 200;

   cfg_type cfg = CFG_RESET;
   int quarter_sine [0:SINE_ENTRIES];
   mesh_element_type expected_elements [$];
   mesh_element_type want;
   mesh_element_type got;
   int errs = 0;

   // Quarter-wave table entry from a Taylor series through x^13 in unsigned Q30.
   function automatic int series_sine(longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      longint r;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum -= longint'(term);
         end else begin
            sum += longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      r = (sum * 32767 + longint'(ONE_Q30 / 2)) / longint'(ONE_Q30);
      if (r > 32767) begin
         r = 32767;
      end
      return int'(r);
   endfunction

   initial begin
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         quarter_sine[k] = series_sine((HALF_PI_Q30 * k) / SINE_ENTRIES);
      end
      quarter_sine[SINE_ENTRIES] = 32767;
   end

   function automatic int signed_sine(logic [PHASE_W-1:0] phase);
      logic [SINE_IDX_W-1:0] idx;
      int mag;
      idx = phase[QUARTER_W-1 -: SINE_IDX_W];
      mag = phase[QUARTER_W] ? quarter_sine[SINE_ENTRIES - idx] : quarter_sine[idx];
      return phase[PHASE_W-1] ? -mag : mag;
   endfunction

   // Magnitude times radius, rounded half up after the Q15 shift, then the sign.
   function automatic logic [POS_W-1:0] scale_by_radius(int s);
      longint unsigned mag;
      longint unsigned prod;
      mag = longint'((s < 0) ? -s : s);
      prod = (mag * cfg.radius + 16384) >> 15;
      if (s < 0) begin
         prod = -prod;
      end
      return prod[POS_W-1:0];
   endfunction

   function automatic logic [TEX_W-1:0] saturate_tex(longint unsigned v);
      return (v > 65535) ? {TEX_W{1'b1}} : v[TEX_W-1:0];
   endfunction

   function automatic mesh_element_type predict_mesh_element(logic is_face,
         logic [POINT_W-1:0] p, logic [RING_W-1:0] r, logic s);
      mesh_element_type e;
      logic [PHASE_W-1:0] ph;
      int n;
      int np;
      int layers;
      int a;
      int b;
      int c;
      bit bad;
      e = '0;
      n = int'(cfg.num_rings);
      np = int'(cfg.num_points);
      bad = n < 3 || np < 3 || n > MAX_RINGS || np > MAX_POINTS;
      if (!bad) begin
         bad = (int'(p) >= np) || (is_face ? (int'(r) >= n - 1) : (int'(r) >= n));
      end
      if (bad) begin
         e.out_of_range = 1'b1;
         return e;
      end
      if (!is_face) begin
         ph = PHASE_W'(int'(p) * int'(cfg.phase_step));
         e.slot_index = SLOT_W'(int'(p) * n + int'(r));
         e.pos_x = scale_by_radius(signed_sine(ph));
         e.pos_y = scale_by_radius(signed_sine(ph + 16'd16384));
         e.pos_z = Z_W'(int'(r) * int'(cfg.height_step));
         e.tex_u = saturate_tex(longint'(int'(p) * int'(cfg.u_step)));
         e.tex_v = saturate_tex(longint'(int'(r) * int'(cfg.v_step)));
      end else begin
         layers = n - 1;
         a = int'(p) * n + int'(r);
         if (!s) begin
            b = a + 1;
            c = b + n;
         end else begin
            c = a + n;
            b = c + 1;
         end
         // The last column of triangles closes the cylinder onto column zero.
         if (int'(p) == np - 1) begin
            if (!s) begin
               c = int'(r) + 1;
            end else begin
               b = int'(r) + 1;
               c = int'(r);
            end
         end
         e.slot_index = SLOT_W'(int'(r) + int'(s) * layers + int'(p) * 2 * layers);
         e.vert_a = VERT_W'(a);
         e.vert_b = VERT_W'(b);
         e.vert_c = VERT_W'(c);
      end
      return e;
   endfunction

   task automatic compare_field(string name, logic [31:0] expv, logic [31:0] gotv);
      if (expv !== gotv) begin
         errs++;
         if (errs <= PRINT_LIMIT) begin
            $display("%0t: %s expected %0h got %0h", $time, name, expv, gotv);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg = CFG_RESET;
         expected_elements.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_NUM_RINGS:   cfg.num_rings = csr_data[CNT_W-1:0];
               REG_NUM_POINTS:  cfg.num_points = csr_data[CNT_W-1:0];
               REG_RADIUS:      cfg.radius = csr_data;
               REG_HEIGHT_STEP: cfg.height_step = csr_data;
               REG_PHASE_STEP:  cfg.phase_step = csr_data;
               REG_U_STEP:      cfg.u_step = csr_data;
               REG_V_STEP:      cfg.v_step = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_elements.size() == 0) begin
               errs++;
               if (errs <= PRINT_LIMIT) begin
                  $display("%0t: result arrived with no request waiting", $time);
               end
            end else begin
               want = expected_elements.pop_front();
               got.out_of_range = rsp_tuser;
               got.slot_index = rsp_tdata[SLOT_W-1:0];
               got.vert_a = rsp_tdata[VERT_LO +: VERT_W];
               got.vert_b = rsp_tdata[VERT_LO + VERT_W +: VERT_W];
               got.vert_c = rsp_tdata[VERT_LO + 2 * VERT_W +: VERT_W];
               got.pos_x = rsp_tdata[ATTR_LO +: POS_W];
               got.pos_y = rsp_tdata[ATTR_LO + POS_W +: POS_W];
               got.pos_z = rsp_tdata[ATTR_LO + 2 * POS_W +: Z_W];
               got.tex_u = rsp_tdata[ATTR_LO + 2 * POS_W + Z_W +: TEX_W];
               got.tex_v = rsp_tdata[ATTR_LO + 2 * POS_W + Z_W + TEX_W +: TEX_W];
               compare_field("out_of_range", 32'(want.out_of_range),
                             32'(got.out_of_range));
               compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
               compare_field("vert_a", 32'(want.vert_a), 32'(got.vert_a));
               compare_field("vert_b", 32'(want.vert_b), 32'(got.vert_b));
               compare_field("vert_c", 32'(want.vert_c), 32'(got.vert_c));
               compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
               compare_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
               compare_field("pos_z", 32'(want.pos_z), 32'(got.pos_z));
               compare_field("tex_u", 32'(want.tex_u), 32'(got.tex_u));
               compare_field("tex_v", 32'(want.tex_v), 32'(got.tex_v));
            end
         end
         if (req_tvalid && req_tready) begin
            expected_elements.push_back(predict_mesh_element(req_tuser,
               req_tdata[POINT_W-1:0], req_tdata[POINT_W +: RING_W],
               req_tdata[POINT_W + RING_W]));
         end
      end
      fail_count <= errs;
      pending <= expected_elements.size();
   end

endmodule

@@ sim/tb_cylinder_mesh_generator.sv @@
// Testbench top for the cylinder mesh generator: clock, reset, request and register
// stimulus, random back-pressure on results and the final verdict.
// Depends on cmg_pkg, cmg_result_checker and cylinder_mesh_generator.
module tb_cylinder_mesh_generator;
   import cmg_pkg::*;

   localparam logic CMD_VERTEX = 1'b0;
   localparam logic CMD_FACE = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;
   localparam int HOLD_CYCLES = 200;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int cur_rings = 3;
   int cur_points = 3;
   bit send_burst = 1'b0;
   bit hold_go = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   cylinder_mesh_generator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cmg_result_checker results (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("status: fail");
      $finish;
   end

   function automatic int draw_gap(bit burst);
      if (burst) begin
         return 0;
      end
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 18));
   endfunction

   task automatic send_request(input logic cmd, input int p, input int r, input logic s);
      int gap;
      gap = draw_gap(send_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= REQ_W'({s, r[RING_W-1:0], p[POINT_W-1:0]});
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Mostly requests inside the mesh, biased toward the last column; the rest anywhere.
   task automatic random_request();
      logic cmd;
      logic s;
      int p;
      int r;
      bit sizes_ok;
      cmd = 1'($urandom_range(0, 1));
      s = 1'($urandom_range(0, 1));
      sizes_ok = cur_rings >= 3 && cur_points >= 3 && cur_rings <= MAX_RINGS
                 && cur_points <= MAX_POINTS;
      if (!sizes_ok || $urandom_range(0, 7) == 0) begin
         p = $urandom_range(0, 255);
         r = $urandom_range(0, 255);
      end else begin
         p = ($urandom_range(0, 3) == 0) ? cur_points - 1 : $urandom_range(0, cur_points - 1);
         r = (cmd == CMD_FACE) ? $urandom_range(0, cur_rings - 2)
                               : $urandom_range(0, cur_rings - 1);
      end
      send_request(cmd, p, r, s);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   task automatic apply_settings(input int n, input int pts, input logic [15:0] rad,
         input logic [15:0] hgt, input logic [15:0] ph, input logic [15:0] u,
         input logic [15:0] v);
      write_reg(REG_NUM_RINGS, 16'(n));
      write_reg(REG_NUM_POINTS, 16'(pts));
      write_reg(REG_RADIUS, rad);
      write_reg(REG_HEIGHT_STEP, hgt);
      write_reg(REG_PHASE_STEP, ph);
      write_reg(REG_U_STEP, u);
      write_reg(REG_V_STEP, v);
      csr_valid <= 1'b0;
      cur_rings = n & 'h1FF;
      cur_points = pts & 'h1FF;
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int pts;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a three by three mesh, the wrap on the last column, edges.
      send_request(CMD_VERTEX, 0, 0, 1'b0);
      send_request(CMD_VERTEX, 1, 1, 1'b1);
      send_request(CMD_VERTEX, 2, 2, 1'b0);
      send_request(CMD_FACE, 0, 0, 1'b0);
      send_request(CMD_FACE, 0, 0, 1'b1);
      send_request(CMD_FACE, 1, 1, 1'b1);
      send_request(CMD_FACE, 2, 1, 1'b0);
      send_request(CMD_FACE, 2, 1, 1'b1);
      send_request(CMD_VERTEX, 3, 0, 1'b0);
      send_request(CMD_VERTEX, 0, 3, 1'b0);
      send_request(CMD_FACE, 0, 2, 1'b0);
      send_request(CMD_FACE, 3, 0, 1'b1);
      send_request(CMD_VERTEX, 255, 255, 1'b1);

      // Largest mesh with full-scale radius and height.
      wait_for_results();
      apply_settings(256, 256, 16'hFFFF, 16'hFFFF, 16'd256, 16'd256, 16'd256);
      send_request(CMD_VERTEX, 255, 255, 1'b0);
      send_request(CMD_VERTEX, 128, 0, 1'b1);
      send_request(CMD_VERTEX, 64, 17, 1'b0);
      send_request(CMD_FACE, 255, 254, 1'b0);
      send_request(CMD_FACE, 255, 254, 1'b1);
      send_request(CMD_FACE, 0, 255, 1'b0);
      send_request(CMD_FACE, 254, 254, 1'b1);
      repeat (60) random_request();

      for (phase = 0; phase < 8; phase++) begin
         wait_for_results();
         case (phase)
            0: apply_settings(3, 3, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: begin
               write_reg(REG_SPARE, 16'($urandom));
               apply_settings('hFFFF, 2, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            end
            2: apply_settings(3, 257, 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
            3: apply_settings(200, 255, 16'h8000, 16'($urandom), 16'd257, 16'hFFFF, 16'hFFFF);
            default: begin
               n = $urandom_range(0, 1) ? $urandom_range(3, 16) : $urandom_range(3, 256);
               pts = $urandom_range(0, 1) ? $urandom_range(3, 16) : $urandom_range(3, 256);
               apply_settings(n, pts, 16'($urandom), 16'($urandom),
                              $urandom_range(0, 1) ? 16'(65536 / pts) : 16'($urandom),
                              $urandom_range(0, 1) ? 16'(65536 / pts) : 16'($urandom),
                              $urandom_range(0, 1) ? 16'(65536 / n) : 16'($urandom));
            end
         endcase
         if (phase == 4) begin
            hold_go <= 1'b1;
         end
         send_burst = ($urandom_range(0, 3) == 0);
         repeat (50) random_request();
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : result_side
      int gap;
      int served;
      bit burst;
      bit held;
      served = 0;
      burst = 1'b0;
      held = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (served % 40 == 0) begin
            burst = ($urandom_range(0, 2) == 0);
         end
         // One long hold-off lets the pipeline fill and stall the request side.
         if (hold_go && !held) begin
            gap = HOLD_CYCLES;
            held = 1'b1;
         end else begin
            gap = draw_gap(burst);
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         served++;
      end
   end

endmodule

@@ cylinder_mesh_generator.f @@
src/cmg_pkg.sv
src/cmg_sine_rom.sv
src/cmg_scale.sv
src/cylinder_mesh_generator.sv
src/cmg_checker.sv
sim/cmg_result_checker.sv
sim/tb_cylinder_mesh_generator.sv
